// ===== src/sedt_pkg.sv =====
// shared types, constants and codes for the endpoint demux table
// no dependencies
`timescale 1ns / 1ps

package sedt_pkg;

   localparam int TableDepth  = 16;
   localparam int IdxBits     = $clog2(TableDepth);
   localparam int AddrBits    = 32;
   localparam int QueueDepth  = 2;

   localparam logic [15:0] PortFirstReset = 16'd49152;
   localparam logic [15:0] PortLastReset  = 16'd65535;
   localparam logic [15:0] LastEphReset   = 16'd49152;

   typedef enum logic [2:0] {
      FUNC_EPHEMERAL = 3'd0,
      FUNC_BIND      = 3'd1,
      FUNC_CONNECT   = 3'd2,
      FUNC_FREE      = 3'd3,
      FUNC_LOOKUP    = 3'd4,
      FUNC_SIMPLE    = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOPORT  = 3'd1,
      ST_DUP     = 3'd2,
      ST_FULL    = 3'd3,
      ST_NOMATCH = 3'd4,
      ST_AMBIG   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_PORT_FIRST  = 2'd0,
      REG_PORT_LAST   = 2'd1,
      REG_SUBNET_ADDR = 2'd2,
      REG_SUBNET_MASK = 2'd3
   } reg_type;

   // one classified request as queued between front and back
   typedef struct packed {
      logic [2:0]          func;
      logic                func_bad;
      logic [3:0]          device;
      logic [AddrBits-1:0] local_address;
      logic [15:0]         local_port;
      logic [AddrBits-1:0] peer_address;
      logic [15:0]         peer_port;
      logic [3:0]          entry_index;
   } op_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  index;
      logic [15:0] port;
   } res_type;

   typedef struct packed {
      logic [15:0]         port_first;
      logic [15:0]         port_last;
      logic [AddrBits-1:0] subnet_address;
      logic [AddrBits-1:0] subnet_mask;
   } cfg_type;

endpackage

// ===== src/sedt_front.sv =====
// front end: accepts requests, classifies func, holds a short queue
// depends on sedt_pkg
`timescale 1ns / 1ps

module sedt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_func,
   input  logic [3:0]             req_device,
   input  logic [31:0]            req_local_address,
   input  logic [15:0]            req_local_port,
   input  logic [31:0]            req_peer_address,
   input  logic [15:0]            req_peer_port,
   input  logic [3:0]             req_entry_index,
   output logic                   op_valid,
   input  logic                   op_ready,
   output sedt_pkg::op_type       op
);
   import sedt_pkg::*;

   op_type      q_ff [QueueDepth];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   op_type      new_op;
   logic        push, pop;

   always_comb begin
      new_op.func          = req_func;
      new_op.func_bad      = (req_func > FUNC_SIMPLE);
      new_op.device        = req_device;
      new_op.local_address = req_local_address[AddrBits-1:0];
      new_op.local_port    = req_local_port;
      new_op.peer_address  = req_peer_address[AddrBits-1:0];
      new_op.peer_port     = req_peer_port;
      new_op.entry_index   = req_entry_index;
   end

   assign req_ready = (count_ff != 2'(QueueDepth));
   assign op_valid  = (count_ff != 2'd0);
   assign op        = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule

// ===== src/sedt_back.sv =====
// back end: entry table, match logic and ephemeral port search
// depends on sedt_pkg
`timescale 1ns / 1ps

module sedt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sedt_pkg::cfg_type    cfg,
   input  logic                 op_valid,
   output logic                 op_ready,
   input  sedt_pkg::op_type     op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sedt_pkg::res_type    res
);
   import sedt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MATCH = 5'b00010,
      S_DEC   = 5'b00100,
      S_SRCH  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [AddrBits-1:0]   e_la_ff [TableDepth];
   logic [15:0]           e_lp_ff [TableDepth];
   logic [AddrBits-1:0]   e_pa_ff [TableDepth];
   logic [15:0]           e_pp_ff [TableDepth];
   logic [3:0]            e_dev_ff [TableDepth];
   logic [15:0]           last_eph_ff, last_eph_in;

   op_type  cur_ff, cur_in;
   res_type res_ff, res_in;
   res_type out_ff, out_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // per-entry match flags, registered
   logic [TableDepth-1:0] dup_ff, hit3_ff, hit2_ff, hit1_ff, hit0_ff;
   logic [TableDepth-1:0] exact_ff, gen0_ff, gen1_ff, gen2_ff;
   logic [TableDepth-1:0] dup_c, hit3_c, hit2_c, hit1_c, hit0_c;
   logic [TableDepth-1:0] exact_c, gen0_c, gen1_c, gen2_c;

   // ephemeral search
   logic [15:0] port_ff, port_in;
   logic [16:0] tries_ff, tries_in;
   logic [15:0] port_next;

   logic              wr_en;
   logic [IdxBits-1:0] wr_idx;
   logic [15:0]       wr_lp;
   logic [AddrBits-1:0] wr_pa;
   logic [15:0]       wr_pp;

   logic [AddrBits-1:0] net;
   logic [TableDepth-1:0] dup_sel, used_c;

   function automatic logic [IdxBits:0] first_set(input logic [TableDepth-1:0] v);
      logic [IdxBits:0] r;
      r = {1'b1, {IdxBits{1'b0}}};
      for (int k = TableDepth - 1; k >= 0; k--) begin
         if (v[k]) r = {1'b0, IdxBits'(k)};
      end
      return r;
   endfunction

   function automatic logic multi(input logic [TableDepth-1:0] v);
      return (v & (v - 1'b1)) != '0;
   endfunction

   logic [IdxBits:0] free_f, f3, f2, f1, f0, fx, fg0, fg1, fg2, fs;
   assign free_f = first_set(~valid_ff);
   assign f3  = first_set(hit3_ff);
   assign f2  = first_set(hit2_ff);
   assign f1  = first_set(hit1_ff);
   assign f0  = first_set(hit0_ff);
   assign fx  = first_set(exact_ff);
   assign fg0 = first_set(gen0_ff);
   assign fg1 = first_set(gen1_ff);
   assign fg2 = first_set(gen2_ff);
   assign net = cfg.subnet_address & cfg.subnet_mask;

   always_comb begin
      for (int i = 0; i < TableDepth; i++) begin
         logic dev_ok, lp_eq, lx, lw, px, pw, ax, aw, ok;
         dev_ok = (e_dev_ff[i] == 4'd0) || (e_dev_ff[i] == cur_ff.device);
         lp_eq  = valid_ff[i] && (e_lp_ff[i] == cur_ff.local_port);
         lx = (e_la_ff[i] == cur_ff.local_address);
         lw = !lx && ((e_la_ff[i] == '0) ||
              ((e_la_ff[i] == net) && ((cur_ff.local_address & cfg.subnet_mask) == net)));
         px = (e_pp_ff[i] == cur_ff.peer_port);
         pw = (e_pp_ff[i] == 16'd0);
         ax = (e_pa_ff[i] == cur_ff.peer_address);
         aw = (e_pa_ff[i] == '0);
         ok = lp_eq && dev_ok && (px || pw) && (ax || aw);
         hit3_c[i] = ok && lx && ax && px;
         hit2_c[i] = ok && lw && ax && px;
         hit1_c[i] = ok && lx && aw && pw;
         hit0_c[i] = ok && lw && aw && pw;
         // bind clashes on device, local address and port alone, connect also on peer address and port
         dup_c[i] = lp_eq && lx && dev_ok &&
                    ((cur_ff.func == FUNC_BIND) || (ax && px));
         exact_c[i] = lp_eq && lx && px && ax;
         gen0_c[i]  = lp_eq && (e_la_ff[i] != '0) && !aw;
         gen1_c[i]  = lp_eq && ((e_la_ff[i] == '0) != aw);
         gen2_c[i]  = lp_eq && (e_la_ff[i] == '0) && aw;
         used_c[i]  = valid_ff[i] && (e_lp_ff[i] == port_next);
      end
   end
   assign dup_sel = dup_ff;

   always_comb begin
      port_next = port_ff + 16'd1;
      if (port_next < cfg.port_first || port_next > cfg.port_last) begin
         port_next = cfg.port_first;
      end
   end

   assign op_ready  = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign res       = out_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      valid_in     = valid_ff;
      last_eph_in  = last_eph_ff;
      port_in      = port_ff;
      tries_in     = tries_ff;
      fs           = fx;
      wr_en        = 1'b0;
      wr_idx       = free_f[IdxBits-1:0];
      wr_lp        = cur_ff.local_port;
      wr_pa        = cur_ff.peer_address;
      wr_pp        = cur_ff.peer_port;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               cur_in   = op;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_DEC;
            port_in  = last_eph_ff;
            tries_in = {1'b0, cfg.port_last} - {1'b0, cfg.port_first};
         end
         S_DEC: begin
            res_in   = '{status: ST_NOMATCH, index: 4'd0, port: 16'd0};
            state_in = S_OUT;
            if (cur_ff.func_bad) begin
               res_in.status = ST_NOMATCH;
            end else begin
               case (cur_ff.func)
                  FUNC_EPHEMERAL: begin
                     if (free_f[IdxBits]) res_in.status = ST_FULL;
                     else state_in = S_SRCH;
                  end
                  FUNC_BIND, FUNC_CONNECT: begin
                     if (dup_sel != '0) res_in.status = ST_DUP;
                     else if (free_f[IdxBits]) res_in.status = ST_FULL;
                     else begin
                        wr_en = 1'b1;
                        if (cur_ff.func == FUNC_BIND) begin
                           wr_pa = '0;
                           wr_pp = 16'd0;
                        end
                        valid_in[free_f[IdxBits-1:0]] = 1'b1;
                        res_in = '{status: ST_OK, index: 4'(free_f[IdxBits-1:0]),
                                   port: cur_ff.local_port};
                     end
                  end
                  FUNC_FREE: begin
                     if ({1'b0, cur_ff.entry_index} < 5'(TableDepth) &&
                         valid_ff[cur_ff.entry_index[IdxBits-1:0]]) begin
                        valid_in[cur_ff.entry_index[IdxBits-1:0]] = 1'b0;
                        res_in = '{status: ST_OK, index: cur_ff.entry_index,
                                   port: e_lp_ff[cur_ff.entry_index[IdxBits-1:0]]};
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (!f3[IdxBits]) begin
                        res_in = '{status: multi(hit3_ff) ? ST_AMBIG : ST_OK,
                                   index: 4'(f3[IdxBits-1:0]),
                                   port: e_lp_ff[f3[IdxBits-1:0]]};
                     end else if (!f2[IdxBits]) begin
                        res_in = '{status: multi(hit2_ff) ? ST_AMBIG : ST_OK,
                                   index: 4'(f2[IdxBits-1:0]),
                                   port: e_lp_ff[f2[IdxBits-1:0]]};
                     end else if (!f1[IdxBits]) begin
                        res_in = '{status: multi(hit1_ff) ? ST_AMBIG : ST_OK,
                                   index: 4'(f1[IdxBits-1:0]),
                                   port: e_lp_ff[f1[IdxBits-1:0]]};
                     end else if (!f0[IdxBits]) begin
                        res_in = '{status: multi(hit0_ff) ? ST_AMBIG : ST_OK,
                                   index: 4'(f0[IdxBits-1:0]),
                                   port: e_lp_ff[f0[IdxBits-1:0]]};
                     end
                  end
                  FUNC_SIMPLE: begin
                     fs = !fx[IdxBits] ? fx : !fg0[IdxBits] ? fg0 :
                          !fg1[IdxBits] ? fg1 : fg2;
                     if (!fs[IdxBits]) begin
                        res_in = '{status: ST_OK, index: 4'(fs[IdxBits-1:0]),
                                   port: e_lp_ff[fs[IdxBits-1:0]]};
                     end
                  end
                  default: res_in.status = ST_NOMATCH;
               endcase
            end
         end
         S_SRCH: begin
            // one candidate port per cycle
            if (tries_ff[16]) begin
               res_in   = '{status: ST_NOPORT, index: 4'd0, port: 16'd0};
               state_in = S_OUT;
            end else begin
               tries_in = tries_ff - 17'd1;
               port_in  = port_next;
               if (port_next != 16'd0 && used_c == '0) begin
                  wr_en  = 1'b1;
                  wr_lp  = port_next;
                  wr_pa  = '0;
                  wr_pp  = 16'd0;
                  valid_in[free_f[IdxBits-1:0]] = 1'b1;
                  last_eph_in = port_next;
                  res_in = '{status: ST_OK, index: 4'(free_f[IdxBits-1:0]),
                             port: port_next};
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         last_eph_ff  <= LastEphReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         last_eph_ff  <= last_eph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
      port_ff  <= port_in;
      tries_ff <= tries_in;
      dup_ff   <= dup_c;
      hit3_ff  <= hit3_c;
      hit2_ff  <= hit2_c;
      hit1_ff  <= hit1_c;
      hit0_ff  <= hit0_c;
      exact_ff <= exact_c;
      gen0_ff  <= gen0_c;
      gen1_ff  <= gen1_c;
      gen2_ff  <= gen2_c;
      if (wr_en) begin
         e_la_ff[wr_idx]  <= cur_ff.local_address;
         e_lp_ff[wr_idx]  <= wr_lp;
         e_pa_ff[wr_idx]  <= wr_pa;
         e_pp_ff[wr_idx]  <= wr_pp;
         e_dev_ff[wr_idx] <= cur_ff.device;
      end
   end

endmodule

// ===== src/socket_endpoint_demux_table.sv =====
// Endpoint demux table: a request passes from acceptance to a response through
// the queue, a parallel compare over all 16 entries, a decision and the output
// register. An ephemeral allocation adds a search that tests one candidate port
// per cycle against the whole table, across the range port_first to port_last,
// and gives up when the range is exhausted. A two-entry request queue lets the
// front keep accepting while the back works.
// top level: csr registers, front queue and back end; depends on sedt_pkg,
// sedt_front and sedt_back
`timescale 1ns / 1ps

module socket_endpoint_demux_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_device,
   input  logic [31:0] req_local_address,
   input  logic [15:0] req_local_port,
   input  logic [31:0] req_peer_address,
   input  logic [15:0] req_peer_port,
   input  logic [3:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_entry_index_res,
   output logic [15:0] rsp_assigned_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sedt_pkg::*;

   cfg_type cfg_ff, cfg_in;
   op_type  op;
   res_type res;
   logic    op_valid, op_ready;
   logic    wr;
   reg_type ra;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign ra     = reg_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (ra)
            REG_PORT_FIRST:  cfg_in.port_first     = pwdata[15:0];
            REG_PORT_LAST:   cfg_in.port_last      = pwdata[15:0];
            REG_SUBNET_ADDR: cfg_in.subnet_address = pwdata[AddrBits-1:0];
            REG_SUBNET_MASK: cfg_in.subnet_mask    = pwdata[AddrBits-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (ra)
         REG_PORT_FIRST:  prdata = {16'd0, cfg_ff.port_first};
         REG_PORT_LAST:   prdata = {16'd0, cfg_ff.port_last};
         REG_SUBNET_ADDR: prdata = cfg_ff.subnet_address;
         REG_SUBNET_MASK: prdata = cfg_ff.subnet_mask;
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{port_first: PortFirstReset, port_last: PortLastReset,
                     subnet_address: '0, subnet_mask: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sedt_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_device,
      .req_local_address, .req_local_port, .req_peer_address, .req_peer_port,
      .req_entry_index, .op_valid, .op_ready, .op
   );

   sedt_back u_back (
      .clock, .reset, .cfg(cfg_ff), .op_valid, .op_ready, .op,
      .rsp_valid, .rsp_ready, .res
   );

   assign rsp_status          = res.status;
   assign rsp_entry_index_res = res.index;
   assign rsp_assigned_port   = res.port;

endmodule

// ===== tb/sedt_checker.sv =====
// checker for the endpoint demux table: watches requests, csr writes and responses,
// predicts every response and compares it; depends on sedt_pkg
`timescale 1ns / 1ps

module sedt_checker
   import sedt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_device,
   input  logic [31:0] req_local_address,
   input  logic [15:0] req_local_port,
   input  logic [31:0] req_peer_address,
   input  logic [15:0] req_peer_port,
   input  logic [3:0]  req_entry_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [3:0]  rsp_entry_index_res,
   input  logic [15:0] rsp_assigned_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);

   logic        ep_valid [TableDepth];
   logic [31:0] ep_laddr [TableDepth];
   logic [15:0] ep_lport [TableDepth];
   logic [31:0] ep_paddr [TableDepth];
   logic [15:0] ep_pport [TableDepth];
   logic [3:0]  ep_dev   [TableDepth];
   logic [15:0] last_eph;
   cfg_type     cfg;
   res_type     expected_q[$];

   function automatic res_type mk(status_type st, int idx, logic [15:0] port);
      res_type r;
      r.status = st;
      r.index  = idx[3:0];
      r.port   = port;
      return r;
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < TableDepth; i++)
         if (!ep_valid[i]) return i;
      return -1;
   endfunction

   function automatic bit port_in_use(logic [15:0] port);
      for (int i = 0; i < TableDepth; i++)
         if (ep_valid[i] && ep_lport[i] == port) return 1;
      return 0;
   endfunction

   function automatic void put(int s, logic [31:0] la, logic [15:0] lp, logic [31:0] pa,
                               logic [15:0] pp, logic [3:0] dev);
      ep_valid[s] = 1;
      ep_laddr[s] = la;
      ep_lport[s] = lp;
      ep_paddr[s] = pa;
      ep_pport[s] = pp;
      ep_dev[s]   = dev;
   endfunction

   function automatic res_type endpoint_predict(logic [2:0] func, logic [3:0] dev,
         logic [31:0] la, logic [15:0] lp, logic [31:0] pa, logic [15:0] pp, logic [3:0] ix);
      int          s;
      int          tries;
      logic [15:0] port;
      int          cnt [4];
      int          first [4];
      logic [31:0] net;
      bit          lx, lw, px, pw, ax, aw;
      bit          hit [4];
      int          gen, best;
      bit          found;
      case (func)
         FUNC_EPHEMERAL: begin
            s = lowest_free();
            if (s < 0) return mk(ST_FULL, 0, 0);
            tries = int'(cfg.port_last) - int'(cfg.port_first);
            port = last_eph;
            while (1) begin
               if (tries < 0) return mk(ST_NOPORT, 0, 0);
               tries--;
               port = port + 16'd1;
               if (port < cfg.port_first || port > cfg.port_last) port = cfg.port_first;
               if (port != 0 && !port_in_use(port)) break;
            end
            last_eph = port;
            put(s, la, port, 0, 0, dev);
            return mk(ST_OK, s, port);
         end
         FUNC_BIND, FUNC_CONNECT: begin
            if (func == FUNC_BIND) begin
               pa = 0;
               pp = 0;
            end
            for (int i = 0; i < TableDepth; i++) begin
               if (!ep_valid[i] || ep_lport[i] != lp || ep_laddr[i] != la) continue;
               if (ep_dev[i] != dev && ep_dev[i] != 0) continue;
               if (func == FUNC_CONNECT && (ep_pport[i] != pp || ep_paddr[i] != pa)) continue;
               return mk(ST_DUP, 0, 0);
            end
            s = lowest_free();
            if (s < 0) return mk(ST_FULL, 0, 0);
            put(s, la, lp, pa, pp, dev);
            return mk(ST_OK, s, lp);
         end
         FUNC_FREE: begin
            if (!ep_valid[ix]) return mk(ST_NOMATCH, 0, 0);
            ep_valid[ix] = 0;
            return mk(ST_OK, ix, ep_lport[ix]);
         end
         FUNC_LOOKUP: begin
            net = cfg.subnet_address & cfg.subnet_mask;
            for (int c = 0; c < 4; c++) begin
               cnt[c] = 0;
               first[c] = 0;
            end
            for (int i = 0; i < TableDepth; i++) begin
               if (!ep_valid[i] || ep_lport[i] != lp) continue;
               if (ep_dev[i] != 0 && ep_dev[i] != dev) continue;
               lx = (ep_laddr[i] == la);
               lw = 0;
               if (!lx) begin
                  if (ep_laddr[i] == 0) lw = 1;
                  else if (ep_laddr[i] == net && (la & cfg.subnet_mask) == net) lw = 1;
                  else continue;
               end
               px = (ep_pport[i] == pp);
               pw = (ep_pport[i] == 0);
               ax = (ep_paddr[i] == pa);
               aw = (ep_paddr[i] == 0);
               if (!(px || pw) || !(ax || aw)) continue;
               hit[3] = lx && ax && px;
               hit[2] = lw && ax && px;
               hit[1] = lx && aw && pw;
               hit[0] = lw && aw && pw;
               for (int c = 0; c < 4; c++)
                  if (hit[c]) begin
                     if (cnt[c] == 0) first[c] = i;
                     cnt[c]++;
                  end
            end
            for (int c = 3; c >= 0; c--)
               if (cnt[c] != 0)
                  return mk(cnt[c] > 1 ? ST_AMBIG : ST_OK, first[c], ep_lport[first[c]]);
            return mk(ST_NOMATCH, 0, 0);
         end
         FUNC_SIMPLE: begin
            gen = 3;
            best = 0;
            found = 0;
            for (int i = 0; i < TableDepth; i++) begin
               if (!ep_valid[i] || ep_lport[i] != lp) continue;
               if (ep_laddr[i] == la && ep_pport[i] == pp && ep_paddr[i] == pa)
                  return mk(ST_OK, i, ep_lport[i]);
               s = (ep_laddr[i] == 0) + (ep_paddr[i] == 0);
               if (s < gen) begin
                  gen = s;
                  best = i;
                  found = 1;
               end
            end
            if (found) return mk(ST_OK, best, ep_lport[best]);
            return mk(ST_NOMATCH, 0, 0);
         end
         default: return mk(ST_NOMATCH, 0, 0);
      endcase
   endfunction

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         for (int i = 0; i < TableDepth; i++) ep_valid[i] = 0;
         last_eph = LastEphReset;
         cfg.port_first = PortFirstReset;
         cfg.port_last = PortLastReset;
         cfg.subnet_address = '0;
         cfg.subnet_mask = '0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready)
            case (reg_type'(paddr[3:2]))
               REG_PORT_FIRST:  cfg.port_first = pwdata[15:0];
               REG_PORT_LAST:   cfg.port_last = pwdata[15:0];
               REG_SUBNET_ADDR: cfg.subnet_address = pwdata;
               REG_SUBNET_MASK: cfg.subnet_mask = pwdata;
               default: ;
            endcase
         if (req_valid && req_ready) begin
            want = endpoint_predict(req_func, req_device, req_local_address,
               req_local_port, req_peer_address, req_peer_port, req_entry_index);
            expected_q.insert(expected_q.size(), want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_status != want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_entry_index_res != want.index) begin
                  $error("entry_index_res expected %0d actual %0d", want.index,
                         rsp_entry_index_res);
                  fail_count++;
               end
               if (rsp_assigned_port != want.port) begin
                  $error("assigned_port expected %0d actual %0d", want.port,
                         rsp_assigned_port);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// testbench top for the endpoint demux table: clock, reset, csr writes, request
// stimulus and response back-pressure; depends on sedt_pkg, sedt_checker, DUT
`timescale 1ns / 1ps

module tb;
   import sedt_pkg::*;

   localparam int CycleLimit = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_func = 0;
   logic [3:0]  req_device = 0;
   logic [31:0] req_local_address = 0;
   logic [15:0] req_local_port = 0;
   logic [31:0] req_peer_address = 0;
   logic [15:0] req_peer_port = 0;
   logic [3:0]  req_entry_index = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_entry_index_res;
   logic [15:0] rsp_assigned_port;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          quiet = 0;
   bit          start_hold = 0;
   int          hold_left = 0;

   socket_endpoint_demux_table DUT (.*);
   sedt_checker checker_i (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (start_hold) begin
         start_hold = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= quiet || $urandom_range(99) >= 7;
      end
   end

   task automatic csr_write(reg_type r, logic [31:0] v);
      @(negedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {r, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic issue(logic [2:0] f, logic [3:0] dev, logic [31:0] la, logic [15:0] lp,
                        logic [31:0] pa, logic [15:0] pp, logic [3:0] ix);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_device <= dev;
      req_local_address <= la;
      req_local_port <= lp;
      req_peer_address <= pa;
      req_peer_port <= pp;
      req_entry_index <= ix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(6))
         0, 1: return 32'h0;
         2: return 32'h0A00_0000;
         3: return 32'h0A00_0007;
         4: return 32'hC0A8_0001;
         5: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(6))
         0: return 16'd0;
         1, 2: return 16'd80;
         3: return 16'd1000 + 16'($urandom_range(3));
         4: return 16'd49153;
         5: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_requests(int count);
      logic [2:0] f;
      int         r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            // noise: every field fully random, bad func codes included
            issue(3'($urandom), 4'($urandom), $urandom, 16'($urandom), $urandom,
                  16'($urandom), 4'($urandom));
         end else begin
            if (r < 25) f = FUNC_EPHEMERAL;
            else if (r < 43) f = FUNC_BIND;
            else if (r < 58) f = FUNC_CONNECT;
            else if (r < 76) f = FUNC_FREE;
            else if (r < 90) f = FUNC_LOOKUP;
            else f = FUNC_SIMPLE;
            issue(f, 4'($urandom_range(2)), pick_addr(), pick_port(),
                  $urandom_range(1) ? 32'h0 : pick_addr(),
                  $urandom_range(1) ? 16'h0 : pick_port(), 4'($urandom));
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] first, logic [15:0] last, logic [31:0] sa,
                             logic [31:0] sm);
      csr_write(REG_PORT_FIRST, 32'(first));
      csr_write(REG_PORT_LAST, 32'(last));
      csr_write(REG_SUBNET_ADDR, sa);
      csr_write(REG_SUBNET_MASK, sm);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: defaults, extremes and each operation
      issue(FUNC_EPHEMERAL, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
      issue(FUNC_BIND, 4'd0, 32'h0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 4'h0);
      issue(FUNC_BIND, 4'd0, 32'h0, 16'd0, 32'h0, 16'h0, 4'h0);
      issue(FUNC_BIND, 4'd1, 32'h0, 16'd80, 32'h0, 16'h0, 4'h0);
      issue(FUNC_BIND, 4'd0, 32'h0, 16'd80, 32'h0, 16'h0, 4'h0);
      issue(FUNC_LOOKUP, 4'd1, 32'h0A00_0001, 16'd80, 32'h1, 16'd5, 4'h0);
      issue(FUNC_CONNECT, 4'd1, 32'hC0A8_0001, 16'd80, 32'h0A00_0009, 16'd7, 4'h0);
      issue(FUNC_CONNECT, 4'd1, 32'hC0A8_0001, 16'd80, 32'h0A00_0009, 16'd7, 4'h0);
      issue(FUNC_LOOKUP, 4'd1, 32'hC0A8_0001, 16'd80, 32'h0A00_0009, 16'd7, 4'h0);
      issue(FUNC_LOOKUP, 4'd0, 32'h1234_5678, 16'd80, 32'h1, 16'd5, 4'h0);
      issue(FUNC_LOOKUP, 4'd0, 32'h1, 16'd81, 32'h1, 16'd5, 4'h0);
      issue(FUNC_SIMPLE, 4'd0, 32'hC0A8_0001, 16'd80, 32'h0A00_0009, 16'd7, 4'h0);
      issue(FUNC_SIMPLE, 4'd0, 32'h5, 16'd80, 32'h6, 16'd7, 4'h0);
      issue(FUNC_SIMPLE, 4'd0, 32'h5, 16'd99, 32'h6, 16'd7, 4'h0);
      issue(FUNC_FREE, 4'd0, 32'h0, 16'd0, 32'h0, 16'h0, 4'hF);
      issue(FUNC_FREE, 4'd0, 32'h0, 16'd0, 32'h0, 16'h0, 4'h1);
      issue(3'd6, 4'd0, 32'h0, 16'd0, 32'h0, 16'h0, 4'h0);
      issue(3'd7, 4'd0, 32'h0, 16'd0, 32'h0, 16'h0, 4'h0);
      for (int i = 0; i < 6; i++)
         issue(FUNC_EPHEMERAL, 4'd2, 32'h0, 16'd0, 32'h0, 16'd0, 4'd0);
      random_requests(160);
      drain();

      // small ephemeral range with subnet matching; receiver holds off here
      set_config(16'd1000, 16'd1003, 32'h0A00_0005, 32'hFFFF_FF00);
      start_hold = 1;
      random_requests(200);
      drain();

      set_config(16'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_requests(120);
      drain();

      // no idling on either side in this stretch
      quiet = 1;
      set_config(16'hFFFF, 16'hFFFF, 32'h0A00_0000, 32'hFF00_0000);
      random_requests(150);
      drain();
      quiet = 0;

      set_config(16'd5, 16'd3, 32'h0, 32'h0);
      random_requests(100);
      drain();

      set_config(16'd0, 16'hFFFF, 32'h0A00_0007, 32'hFFFF_FFF8);
      random_requests(200);
      drain();

      set_config(16'd60000, 16'd60007, 32'hC0A8_0001, 32'hFFFF_0000);
      random_requests(150);
      drain();

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
